// ===== design/mpct_pkg.sv =====
// Shared widths, codes and types for the mouse packet cursor tracker.
package mpct_pkg;

    // Payload and register widths
    localparam int BYTE_W    = 8;
    localparam int POS_W     = 8;
    localparam int STEP_W    = 4;
    localparam int ACT_W     = 2;
    localparam int CFG_W     = 8;
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MAX_COL = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ROW = 1'b1;

    // Register reset values
    localparam logic [CFG_W-1:0] MAX_COL_RST = 8'd79;
    localparam logic [CFG_W-1:0] MAX_ROW_RST = 8'd24;

    // Head byte decoding
    localparam logic [BYTE_W-1:0] ACK_BYTE = 8'hFA;
    localparam int OVF_X_BIT   = 6;
    localparam int OVF_Y_BIT   = 7;
    localparam int XSIGN_BIT   = 4;
    localparam int YSIGN_BIT   = 5;
    localparam int BTN_LEFT    = 0;
    localparam int BTN_RIGHT   = 1;
    localparam int BTN_MIDDLE  = 2;

    // Divide by 40 as multiply by 205 then shift by 13 (exact for 0..256)
    localparam logic [7:0] DIV40_MUL   = 8'd205;
    localparam int         DIV40_SHIFT = 13;

    // Button action codes
    localparam logic [ACT_W-1:0] ACT_NONE   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_LEFT   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_MIDDLE = 2'd2;
    localparam logic [ACT_W-1:0] ACT_RIGHT  = 2'd3;

    // Packet byte tracking, one-hot
    typedef enum logic [2:0] {
        PH_HEAD = 3'b001,
        PH_X    = 3'b010,
        PH_Y    = 3'b100
    } t_phase;

endpackage

// ===== design/mpct_rx_if.sv =====
// Input byte channel: valid/ready handshake carrying one raw mouse byte.
interface mpct_rx_if;
    import mpct_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== design/mpct_res_if.sv =====
// Result channel: valid/ready handshake carrying cursor, buttons and steps.
interface mpct_res_if;
    import mpct_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [POS_W-1:0]         cursor_col;
    logic [POS_W-1:0]         cursor_row;
    logic                     moved;
    logic [ACT_W-1:0]         button_action;
    logic signed [STEP_W-1:0] step_x;
    logic signed [STEP_W-1:0] step_y;

    modport source (output valid, output cursor_col, output cursor_row, output moved,
                    output button_action, output step_x, output step_y, input ready);
    modport sink   (input valid, input cursor_col, input cursor_row, input moved,
                    input button_action, input step_x, input step_y, output ready);
endinterface

// ===== design/mouse_packet_cursor_tracker.sv =====
// Mouse packet decoder and clamped text-cursor tracker (top level).
//
//   channel   dir  handshake          payload
//   i_rx      in   valid/ready        rx_byte
//   o_res     out  valid/ready        cursor_col, cursor_row, moved, button_action,
//                                     step_x, step_y
//   i_cfg_*   in   write enable only  register index, write data
//
// One byte per cycle sustained while the result is not stalled. A byte is decoded
// while it sits in the input register; the third byte of a packet loads the result
// register at the end of that decode cycle, so the last byte of a packet passes through
// the input register and then the result register before its result shows.
// Reset is synchronous: packet tracking returns to the head byte, cursor goes to zero, limits to 79/24.
// A stalled result holds the decode stage; the input register still takes a byte
// if it is empty, after which i_rx.ready drops.
module mouse_packet_cursor_tracker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    mpct_rx_if.sink                       i_rx,
    mpct_res_if.source                    o_res,
    input  logic                          i_cfg_we,
    input  logic [mpct_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [mpct_pkg::CFG_W-1:0]     i_cfg_wdata
);
    import mpct_pkg::*;

    // Magnitude / 40, signed by neg xor flip
    function automatic logic signed [STEP_W-1:0] f_scale(input logic [BYTE_W-1:0] raw,
                                                         input logic neg,
                                                         input logic flip);
        logic [BYTE_W:0]   mag;
        logic [15:0]       prod;
        logic [2:0]        q;
        logic [STEP_W-1:0] qe;
        mag  = neg ? (9'd256 - {1'b0, raw}) : {1'b0, raw};
        prod = 16'(mag * DIV40_MUL);
        q    = prod[DIV40_SHIFT +: 3];
        qe   = {1'b0, q};
        return (neg ^ flip) ? signed'(STEP_W'(-qe)) : signed'(qe);
    endfunction

    // Add a step and clamp to 0..limit
    function automatic logic [POS_W-1:0] f_clamp(input logic [POS_W-1:0] pos,
                                                 input logic signed [STEP_W-1:0] step,
                                                 input logic [CFG_W-1:0] limit);
        logic signed [POS_W+1:0] v;
        v = signed'({2'b00, pos}) + (POS_W+2)'(step);
        if (v < 0) begin
            return '0;
        end else if (v > signed'({2'b00, limit})) begin
            return limit;
        end else begin
            return v[POS_W-1:0];
        end
    endfunction

    // Configuration and state registers
    logic [CFG_W-1:0]  r_max_col, r_max_row;
    t_phase            r_phase, n_phase;
    logic [BYTE_W-1:0] r_head, r_xbyte;
    logic [POS_W-1:0]  r_col, r_row;

    // Input register
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;

    // Result register
    logic                     r_out_valid;
    logic [POS_W-1:0]         r_out_col, r_out_row;
    logic                     r_out_moved;
    logic [ACT_W-1:0]         r_out_act;
    logic signed [STEP_W-1:0] r_out_sx, r_out_sy;

    logic                     w_adv, w_fire, w_head_ok, w_emit;
    logic signed [STEP_W-1:0] w_sx, w_sy;
    logic [POS_W-1:0]         w_col, w_row;
    logic [ACT_W-1:0]         w_act;

    // Stage handshake
    assign w_adv      = !r_out_valid || o_res.ready;
    assign w_fire     = r_in_valid && w_adv;
    assign i_rx.ready = !r_in_valid || w_adv;

    // Decode datapath
    assign w_head_ok = (r_in_byte != ACK_BYTE) && !r_in_byte[OVF_X_BIT]
                       && !r_in_byte[OVF_Y_BIT];
    assign w_sx  = f_scale(r_xbyte, r_head[XSIGN_BIT], 1'b0);
    assign w_sy  = f_scale(r_in_byte, r_head[YSIGN_BIT], 1'b1);
    assign w_col = f_clamp(r_col, w_sx, r_max_col);
    assign w_row = f_clamp(r_row, w_sy, r_max_row);
    assign w_emit = w_fire && (r_phase == PH_Y);

    // Button priority: left, middle, right
    always_comb begin
        priority if (r_head[BTN_LEFT]) begin
            w_act = ACT_LEFT;
        end else if (r_head[BTN_MIDDLE]) begin
            w_act = ACT_MIDDLE;
        end else if (r_head[BTN_RIGHT]) begin
            w_act = ACT_RIGHT;
        end else begin
            w_act = ACT_NONE;
        end
    end

    // Packet byte sequencing
    always_comb begin
        n_phase = r_phase;
        if (w_fire) begin
            unique case (r_phase)
                PH_X:    n_phase = PH_Y;
                PH_Y:    n_phase = PH_HEAD;
                default: n_phase = w_head_ok ? PH_X : PH_HEAD;
            endcase
        end
    end

    // Control and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_HEAD;
            r_head      <= '0;
            r_xbyte     <= '0;
            r_col       <= '0;
            r_row       <= '0;
            r_max_col   <= MAX_COL_RST;
            r_max_row   <= MAX_ROW_RST;
        end else begin
            if (i_rx.ready) begin
                r_in_valid <= i_rx.valid;
            end
            if (w_adv) begin
                r_out_valid <= w_emit;
            end
            r_phase <= n_phase;
            if (w_fire && r_phase != PH_X && r_phase != PH_Y && w_head_ok) begin
                r_head <= r_in_byte;
            end
            if (w_fire && r_phase == PH_X) begin
                r_xbyte <= r_in_byte;
            end
            if (w_emit) begin
                r_col <= w_col;
                r_row <= w_row;
            end
            if (i_cfg_we && i_cfg_idx == REG_MAX_COL) begin
                r_max_col <= i_cfg_wdata;
            end
            if (i_cfg_we && i_cfg_idx == REG_MAX_ROW) begin
                r_max_row <= i_cfg_wdata;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_in_byte <= i_rx.rx_byte;
        end
        if (w_emit) begin
            r_out_col   <= w_col;
            r_out_row   <= w_row;
            r_out_moved <= (w_col != r_col) || (w_row != r_row);
            r_out_act   <= w_act;
            r_out_sx    <= w_sx;
            r_out_sy    <= w_sy;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.cursor_col    = r_out_col;
    assign o_res.cursor_row    = r_out_row;
    assign o_res.moved         = r_out_moved;
    assign o_res.button_action = r_out_act;
    assign o_res.step_x        = r_out_sx;
    assign o_res.step_y        = r_out_sy;

endmodule

// ===== design/mpct_checker.sv =====
// Port-level checker for the mouse packet cursor tracker, bound to the top level.
module mpct_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_rx_valid,
    input logic                               i_rx_ready,
    input logic                               i_res_valid,
    input logic                               i_res_ready,
    input logic [mpct_pkg::POS_W-1:0]         i_res_col,
    input logic signed [mpct_pkg::STEP_W-1:0] i_res_sx,
    input logic signed [mpct_pkg::STEP_W-1:0] i_res_sy
);
    import mpct_pkg::*;

    // Stalled result keeps valid
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid)
        else $error("result valid dropped under stall");

    // Stalled result keeps its cursor column and x step
    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> $stable(i_res_col) && $stable(i_res_sx))
        else $error("result payload changed under stall");

    // Scaled steps stay within -6..6
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> i_res_sx >= -6 && i_res_sx <= 6 && i_res_sy >= -6 && i_res_sy <= 6)
        else $error("step out of range");

    // A new result follows an accepted byte through the input and result registers
    a_res_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_res_valid) |-> $past(i_rx_valid && i_rx_ready, 2))
        else $error("result without a preceding byte");

    // Nothing shown after a reset cycle
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result valid after reset");

endmodule

bind mouse_packet_cursor_tracker mpct_checker u_mpct_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_rx_valid  (i_rx.valid),
    .i_rx_ready  (i_rx.ready),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_res_col   (o_res.cursor_col),
    .i_res_sx    (o_res.step_x),
    .i_res_sy    (o_res.step_y)
);

// ===== test/mpct_cursor_checker.sv =====
// Checker for the mouse packet cursor tracker: tracks packets, predicts reports, compares.
module mpct_cursor_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    mpct_rx_if                             rx_mon,
    mpct_res_if                            res_mon,
    input  logic                           i_cfg_we,
    input  logic [mpct_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [mpct_pkg::CFG_W-1:0]     i_cfg_wdata,
    output int                             o_fail_count,
    output int                             o_pending,
    output int                             o_reports_checked
);
    import mpct_pkg::*;

    localparam int MOVE_DIV = 40;

    // One cursor report as it should leave the block
    typedef struct {
        logic [POS_W-1:0]         col;
        logic [POS_W-1:0]         row;
        logic                     moved;
        logic [ACT_W-1:0]         action;
        logic signed [STEP_W-1:0] step_x;
        logic signed [STEP_W-1:0] step_y;
    } t_cursor_report;

    t_cursor_report cursor_reports_due[$];

    // Shadow of the packet framing, cursor and limits
    t_phase           pkt_phase;
    logic [BYTE_W-1:0] head_q;
    logic [BYTE_W-1:0] x_q;
    logic [POS_W-1:0] col_q;
    logic [POS_W-1:0] row_q;
    logic [CFG_W-1:0] col_limit;
    logic [CFG_W-1:0] row_limit;

    int fail_count      = 0;
    int reports_checked = 0;
    int pending_q       = 0;

    assign o_fail_count      = fail_count;
    assign o_pending         = pending_q;
    assign o_reports_checked = reports_checked;

    // Sign-extend a raw delta and divide, truncating toward zero
    function automatic int scale_step(input logic [BYTE_W-1:0] raw, input logic negative);
        int v;
        v = int'(raw);
        if (negative)
            v -= 256;
        return v / MOVE_DIV;
    endfunction

    function automatic logic [POS_W-1:0] clamp_pos(input logic [POS_W-1:0] pos, input int step,
                                                   input logic [CFG_W-1:0] lim);
        int v;
        v = int'(pos) + step;
        if (v < 0)
            v = 0;
        if (v > int'(lim))
            v = int'(lim);
        return v[POS_W-1:0];
    endfunction

    // Advance the packet framing by one accepted byte; the third byte yields a report
    function automatic void track_mouse_byte(input logic [BYTE_W-1:0] b);
        t_cursor_report r;
        int sx;
        int sy;
        case (pkt_phase)
            PH_X: begin
                x_q       = b;
                pkt_phase = PH_Y;
            end
            PH_Y: begin
                pkt_phase = PH_HEAD;
                sx        = scale_step(x_q, head_q[XSIGN_BIT]);
                sy        = -scale_step(b, head_q[YSIGN_BIT]);
                r.col     = clamp_pos(col_q, sx, col_limit);
                r.row     = clamp_pos(row_q, sy, row_limit);
                r.moved   = (r.col != col_q) || (r.row != row_q);
                if (head_q[BTN_LEFT])
                    r.action = ACT_LEFT;
                else if (head_q[BTN_MIDDLE])
                    r.action = ACT_MIDDLE;
                else if (head_q[BTN_RIGHT])
                    r.action = ACT_RIGHT;
                else
                    r.action = ACT_NONE;
                r.step_x = sx[STEP_W-1:0];
                r.step_y = sy[STEP_W-1:0];
                col_q    = r.col;
                row_q    = r.row;
                cursor_reports_due.push_back(r);
            end
            default: begin
                // acknowledge and overflowed heads are dropped
                if (b != ACK_BYTE && !b[OVF_X_BIT] && !b[OVF_Y_BIT]) begin
                    head_q    = b;
                    pkt_phase = PH_X;
                end
            end
        endcase
    endfunction

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%02h, got 0x%02h", name, want, got);
            fail_count++;
        end
    endtask

    // Monitor both channels and the register port
    always @(posedge i_clk) begin
        t_cursor_report want;
        if (!i_rst_n) begin
            pkt_phase = PH_HEAD;
            head_q    = '0;
            x_q       = '0;
            col_q     = '0;
            row_q     = '0;
            col_limit = MAX_COL_RST;
            row_limit = MAX_ROW_RST;
            cursor_reports_due.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_MAX_COL)
                    col_limit = i_cfg_wdata;
                else if (i_cfg_idx == REG_MAX_ROW)
                    row_limit = i_cfg_wdata;
            end
            if (rx_mon.valid && rx_mon.ready)
                track_mouse_byte(rx_mon.rx_byte);
            if (res_mon.valid && res_mon.ready) begin
                reports_checked++;
                if (cursor_reports_due.size() == 0) begin
                    $error("cursor report with none outstanding: col 0x%02h row 0x%02h",
                           res_mon.cursor_col, res_mon.cursor_row);
                    fail_count++;
                end else begin
                    want = cursor_reports_due.pop_front();
                    check_field("cursor_col", want.col, res_mon.cursor_col);
                    check_field("cursor_row", want.row, res_mon.cursor_row);
                    check_field("moved", {7'd0, want.moved}, {7'd0, res_mon.moved});
                    check_field("button_action", {6'd0, want.action},
                                {6'd0, res_mon.button_action});
                    check_field("step_x", {{4{want.step_x[STEP_W-1]}}, want.step_x},
                                {{4{res_mon.step_x[STEP_W-1]}}, res_mon.step_x});
                    check_field("step_y", {{4{want.step_y[STEP_W-1]}}, want.step_y},
                                {{4{res_mon.step_y[STEP_W-1]}}, res_mon.step_y});
                end
            end
        end
        pending_q <= cursor_reports_due.size();
    end

endmodule

// ===== test/mouse_packet_cursor_tracker_tb.sv =====
// Top of the cursor tracker testbench: clock, reset, byte and report traffic, verdict.
module mouse_packet_cursor_tracker_tb;
    import mpct_pkg::*;

    localparam int PIPE_SETTLE = 4;
    localparam int DRAIN_LIMIT = 5000;
    localparam int RUN_LIMIT   = 12 * 300000;

    logic                 i_clk     = 1'b0;
    logic                 i_rst_n   = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx   = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    int  fail_count;
    int  pending;
    int  reports_checked;
    int  bytes_sent     = 0;
    int  limit_settings = 0;
    bit  no_idle        = 1'b0;

    mpct_rx_if  rx ();
    mpct_res_if res ();

    mouse_packet_cursor_tracker i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rx        (rx),
        .o_res       (res),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    mpct_cursor_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .rx_mon            (rx),
        .res_mon           (res),
        .i_cfg_we          (cfg_we),
        .i_cfg_idx         (cfg_idx),
        .i_cfg_wdata       (cfg_wdata),
        .o_fail_count      (fail_count),
        .o_pending         (pending),
        .o_reports_checked (reports_checked)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Offer one byte after a random gap and hold it until the transaction
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            rx.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        rx.valid   <= 1'b1;
        rx.rx_byte <= b;
        @(posedge i_clk);
        while (!rx.ready) @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_packet(input logic [7:0] head, input logic [7:0] dx, input logic [7:0] dy);
        send_byte(head);
        send_byte(dx);
        send_byte(dy);
    endtask

    // Wait for every outstanding report, then let the pipeline empty
    task automatic settle();
        int n;
        n = 0;
        @(posedge i_clk);
        while (pending != 0 && n < DRAIN_LIMIT) begin
            @(posedge i_clk);
            n++;
        end
        repeat (PIPE_SETTLE) @(posedge i_clk);
    endtask

    task automatic write_limits(input logic [CFG_W-1:0] col, input logic [CFG_W-1:0] row);
        rx.valid <= 1'b0;
        settle();
        cfg_we    <= 1'b1;
        cfg_idx   <= REG_MAX_COL;
        cfg_wdata <= col;
        @(posedge i_clk);
        cfg_idx   <= REG_MAX_ROW;
        cfg_wdata <= row;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        limit_settings++;
    endtask

    // Mostly well-formed packets with random content, plus stray and acknowledge bytes
    task automatic send_random_traffic(input int n_bytes);
        int start;
        int pick;
        start = bytes_sent;
        while (bytes_sent - start < n_bytes) begin
            if (((bytes_sent - start) % 64) < 3)
                no_idle = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 85)
                send_packet(8'($urandom_range(0, 255)) & 8'h3F, 8'($urandom_range(0, 255)),
                            8'($urandom_range(0, 255)));
            else if (pick < 94)
                send_byte(8'($urandom_range(0, 255)));
            else
                send_byte(ACK_BYTE);
        end
        no_idle = 1'b0;
    endtask

    // Report sink with random stalls
    initial begin
        int gap;
        res.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            gap = no_idle ? 0 : $urandom_range(0, 5);
            if (gap > 0) begin
                res.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            res.ready <= 1'b1;
            @(posedge i_clk);
            while (!res.valid) @(posedge i_clk);
        end
    end

    // Stimulus and verdict
    initial begin
        rx.valid   <= 1'b0;
        rx.rx_byte <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: dropped heads, step extremes, 0xFA as data, button priority
        send_byte(ACK_BYTE);
        send_byte(8'h48);
        send_byte(8'h88);
        send_byte(8'hC8);
        send_packet(8'h09, 8'hFF, 8'h00);
        send_packet(8'h3C, 8'hFA, 8'h00);
        send_packet(8'h0A, 8'h00, 8'hFF);
        send_packet(8'h18, 8'h00, 8'hFA);
        send_packet(8'h0F, 8'h01, 8'h01);
        send_packet(8'h0E, 8'hFF, 8'hFF);
        send_packet(8'h38, 8'hFF, 8'hFF);

        // Widest limits, then drive the cursor far out so the next limits sit below it
        write_limits(8'd255, 8'd255);
        send_random_traffic(200);
        repeat (14) send_packet(8'h28, 8'hFF, 8'h00);

        write_limits(8'd1, 8'd1);
        send_random_traffic(150);

        // Zero limits pin both coordinates
        write_limits(8'd0, 8'd0);
        send_random_traffic(60);

        repeat (4) begin
            write_limits(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)));
            send_random_traffic(150);
        end

        write_limits(8'd255, 8'd1);
        send_random_traffic(150);
        write_limits(8'd1, 8'd255);
        send_random_traffic(150);

        rx.valid <= 1'b0;
        settle();

        $display("Covered %0d mouse bytes under %0d limit settings plus the reset limits.",
                 bytes_sent, limit_settings);
        $display("Compared %0d cursor reports field by field.", reports_checked);
        if (fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(RUN_LIMIT);
        $display("Some tests failed");
        $finish;
    end

endmodule

// ===== files.f =====
design/mpct_pkg.sv
design/mpct_rx_if.sv
design/mpct_res_if.sv
design/mouse_packet_cursor_tracker.sv
design/mpct_checker.sv
test/mpct_cursor_checker.sv
test/mouse_packet_cursor_tracker_tb.sv
